>>> rtl/psle_pkg.sv
// ----------------------------------------------------------------------------
// psle_pkg
// Shared types and constants for the polygon slice lateral extent core.
// ----------------------------------------------------------------------------
package psle_pkg;

   // Vertices needed before a polygon can report a hit.
   localparam int unsigned MIN_VERTICES = 3;

   // Vertex counter width; the counter saturates at MIN_VERTICES.
   localparam int unsigned VCOUNT_W = 2;

   // Flags that go with each edge job from the front end to the back end.
   typedef struct packed {
      logic has_edge;   // job carries an edge to test
      logic finish;     // last job of the polygon: emit the result after it
      logic few;        // polygon has fewer than MIN_VERTICES vertices
   } job_flags_type;

   localparam int unsigned JOB_FLAGS_W = $bits(job_flags_type);

endpackage

>>> rtl/polygon_slice_lateral_extent_core.sv
// Edge engine: an edge that spans the query with distinct stations passes through
//   pop, multiply, COORD_WIDTH+1 divide steps and update; an edge that misses is
//   only popped. After the last edge the result passes through FIN into its register.
// Flow: the serial divider paces the core; vertex items are held off while the
//   edge job queue is full or a closing edge is pending after a last vertex.
// Reset: synchronous, active high; clears polygon state, queue and result valid.
// ----------------------------------------------------------------------------
// polygon_slice_lateral_extent_core
// Slices a closed polygon at a query station and reports the lateral extent
// of the cut. Front end tracks vertices and issues edge jobs; back end tests
// and interpolates each edge with a multiply and a serial divide.
// ----------------------------------------------------------------------------
module polygon_slice_lateral_extent_core #(
   parameter int COORD_WIDTH = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   // vertex items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_WIDTH-1:0] req_vertex_s,
   input  logic [COORD_WIDTH-1:0] req_vertex_l,
   input  logic [COORD_WIDTH-1:0] req_query_s,
   input  logic                   req_last_vertex,
   // result items, one per polygon
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic                   rsp_too_few_vertices,
   output logic [COORD_WIDTH-1:0] rsp_lateral_min,
   output logic [COORD_WIDTH-1:0] rsp_lateral_max
);

   // Job word: flags on top, then s0, l0, s1, l1, query station.
   localparam int COORDS_W = 5 * COORD_WIDTH;
   localparam int JOB_W    = psle_pkg::JOB_FLAGS_W + COORDS_W;

   logic                    push;
   logic                    full;
   logic                    pop;
   logic                    empty;
   psle_pkg::job_flags_type push_flags;
   psle_pkg::job_flags_type head_flags;
   logic [COORDS_W-1:0]     push_coords;
   logic [COORDS_W-1:0]     head_coords;
   logic [JOB_W-1:0]        head_job;

   // Front end: vertex bookkeeping; the closing edge of a polygon is queued from a
   // pending register after its last vertex, and new items are held off until it is queued.
   psle_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_vertex_s    (req_vertex_s),
      .req_vertex_l    (req_vertex_l),
      .req_query_s     (req_query_s),
      .req_last_vertex (req_last_vertex),
      .job_push        (push),
      .job_flags       (push_flags),
      .job_coords      (push_coords),
      .job_full        (full)
   );

   // Edge job queue: lets the front keep taking items while the divider runs.
   psle_queue #(
      .DATA_W (JOB_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_coords}),
      .full      (full),
      .pop       (pop),
      .pop_data  (head_job),
      .empty     (empty)
   );

   assign head_flags  = psle_pkg::job_flags_type'(head_job[JOB_W-1:COORDS_W]);
   assign head_coords = head_job[COORDS_W-1:0];

   // Back end: span test, interpolation, running extent, result register.
   psle_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .job_empty            (empty),
      .job_flags            (head_flags),
      .job_coords           (head_coords),
      .job_pop              (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_lateral_min      (rsp_lateral_min),
      .rsp_lateral_max      (rsp_lateral_max)
   );

endmodule

>>> rtl/psle_front.sv
// ----------------------------------------------------------------------------
// psle_front
// Accepts vertex items, tracks first/previous vertex and vertex count, and
// turns items into back-end edge jobs; a last vertex after the first adds the closing edge.
// ----------------------------------------------------------------------------
module psle_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [COORD_WIDTH-1:0]        req_vertex_s,
   input  logic [COORD_WIDTH-1:0]        req_vertex_l,
   input  logic [COORD_WIDTH-1:0]        req_query_s,
   input  logic                          req_last_vertex,
   output logic                          job_push,
   output psle_pkg::job_flags_type       job_flags,
   output logic [5*COORD_WIDTH-1:0]      job_coords,
   input  logic                          job_full
);

   logic [psle_pkg::VCOUNT_W-1:0] count_ff, count_in;
   logic [COORD_WIDTH-1:0]        first_s_ff, first_s_in;
   logic [COORD_WIDTH-1:0]        first_l_ff, first_l_in;
   logic [COORD_WIDTH-1:0]        prev_s_ff, prev_s_in;
   logic [COORD_WIDTH-1:0]        prev_l_ff, prev_l_in;
   logic                          pend_ff, pend_in;
   logic                          pend_few_ff, pend_few_in;
   logic [COORD_WIDTH-1:0]        pend_q_ff, pend_q_in;

   logic accept;
   logic first_vtx;
   logic few_now;

   localparam logic [psle_pkg::VCOUNT_W-1:0] CNT_SAT =
      psle_pkg::VCOUNT_W'(psle_pkg::MIN_VERTICES);
   localparam logic [psle_pkg::VCOUNT_W-1:0] CNT_FEW =
      psle_pkg::VCOUNT_W'(psle_pkg::MIN_VERTICES - 1);

   // Closing edge is queued from the pending register; hold off new items until it is queued.
   assign req_ready = !pend_ff && !job_full;
   assign accept    = req_valid && req_ready;
   assign first_vtx = (count_ff == '0);
   // count after this item still below the minimum
   assign few_now   = (count_ff < CNT_FEW);

   always_comb begin
      if (pend_ff) begin
         job_push           = !job_full;
         job_flags.has_edge = 1'b1;
         job_flags.finish   = 1'b1;
         job_flags.few      = pend_few_ff;
         job_coords         = {prev_s_ff, prev_l_ff, first_s_ff, first_l_ff, pend_q_ff};
      end else begin
         job_push           = accept && (!first_vtx || req_last_vertex);
         job_flags.has_edge = !first_vtx;
         job_flags.finish   = req_last_vertex && first_vtx;
         job_flags.few      = few_now;
         job_coords         = {prev_s_ff, prev_l_ff, req_vertex_s, req_vertex_l,
                               req_query_s};
      end
   end

   always_comb begin
      count_in    = count_ff;
      first_s_in  = first_s_ff;
      first_l_in  = first_l_ff;
      prev_s_in   = prev_s_ff;
      prev_l_in   = prev_l_ff;
      pend_in     = pend_ff;
      pend_few_in = pend_few_ff;
      pend_q_in   = pend_q_ff;
      if (pend_ff && !job_full) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         if (first_vtx) begin
            first_s_in = req_vertex_s;
            first_l_in = req_vertex_l;
         end
         prev_s_in = req_vertex_s;
         prev_l_in = req_vertex_l;
         if (req_last_vertex) begin
            count_in = '0;
         end else if (count_ff != CNT_SAT) begin
            count_in = count_ff + 1'b1;
         end
         if (req_last_vertex && !first_vtx) begin
            pend_in     = 1'b1;
            pend_few_in = few_now;
            pend_q_in   = req_query_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         first_s_ff <= '0;
         first_l_ff <= '0;
         prev_s_ff  <= '0;
         prev_l_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         first_s_ff <= first_s_in;
         first_l_ff <= first_l_in;
         prev_s_ff  <= prev_s_in;
         prev_l_ff  <= prev_l_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_few_ff <= pend_few_in;
      pend_q_ff   <= pend_q_in;
   end

endmodule

>>> rtl/psle_queue.sv
// ----------------------------------------------------------------------------
// psle_queue
// Small FIFO of edge jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module psle_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == FILL_MAX);
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/psle_back.sv
// ----------------------------------------------------------------------------
// psle_back
// Edge engine: span test, one multiply, serial restoring divide, running
// min/max, and the result register.
// ----------------------------------------------------------------------------
module psle_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   input  psle_pkg::job_flags_type       job_flags,
   input  logic [5*COORD_WIDTH-1:0]      job_coords,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_too_few_vertices,
   output logic [COORD_WIDTH-1:0]        rsp_lateral_min,
   output logic [COORD_WIDTH-1:0]        rsp_lateral_max
);

   localparam int W     = COORD_WIDTH;
   localparam int CNT_W = $clog2(W + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

   logic [2:0]            state_ff, state_in;
   logic [W:0]            a_ff, a_in;       // |q - s0|
   logic [W:0]            b_ff, b_in;       // |l1 - l0|
   logic [W:0]            d_ff, d_in;       // |s1 - s0|
   logic [W-1:0]          l0_ff, l0_in;
   logic                  neg_ff, neg_in;
   logic                  finish_ff, finish_in;
   logic                  few_ff, few_in;
   logic [W:0]            rem_ff, rem_in;
   logic [W:0]            low_ff, low_in;
   logic [W:0]            quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [W-1:0]   run_min_ff, run_min_in;
   logic signed [W-1:0]   run_max_ff, run_max_in;
   logic                  any_hit_ff, any_hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_few_ff, rsp_few_in;
   logic [W-1:0]          rsp_min_ff, rsp_min_in;
   logic [W-1:0]          rsp_max_ff, rsp_max_in;

   // job head
   logic signed [W-1:0]   h_s0, h_l0, h_s1, h_l1, h_q;
   logic signed [W-1:0]   h_lo, h_hi;
   logic                  h_span;
   logic signed [W:0]     dq, ds, dl;
   logic [W:0]            dq_mag, ds_mag, dl_mag;

   // datapath
   logic [2*W+1:0]        prod;
   logic [W+1:0]          div_t, div_diff;
   logic                  div_ge;
   logic signed [W+1:0]   l_ext, off_ext, l_sum;
   logic signed [W-1:0]   l_val;
   logic                  res_hit;
   logic                  out_free;

   assign {h_s0, h_l0, h_s1, h_l1, h_q} = job_coords;

   assign h_lo   = (h_s0 < h_s1) ? h_s0 : h_s1;
   assign h_hi   = (h_s0 < h_s1) ? h_s1 : h_s0;
   assign h_span = job_flags.has_edge && (h_q >= h_lo) && (h_q <= h_hi);

   assign dq     = {h_q[W-1], h_q} - {h_s0[W-1], h_s0};
   assign ds     = {h_s1[W-1], h_s1} - {h_s0[W-1], h_s0};
   assign dl     = {h_l1[W-1], h_l1} - {h_l0[W-1], h_l0};
   assign dq_mag = dq[W] ? -dq : dq;
   assign ds_mag = ds[W] ? -ds : ds;
   assign dl_mag = dl[W] ? -dl : dl;

   assign job_pop = (state_ff == ST_IDLE) && !job_empty;

   assign prod = a_ff * b_ff;

   // one restoring divide step; remainder stays below d
   assign div_t    = {rem_ff, low_ff[W]};
   assign div_ge   = (div_t >= {1'b0, d_ff});
   assign div_diff = div_t - {1'b0, d_ff};

   // the sum always lies between l0 and l1, so it fits W bits
   assign l_ext   = {l0_ff[W-1], l0_ff[W-1], l0_ff};
   assign off_ext = {1'b0, quo_ff};
   assign l_sum   = neg_ff ? (l_ext - off_ext) : (l_ext + off_ext);
   assign l_val   = l_sum[W-1:0];

   assign res_hit  = !few_ff && any_hit_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      l0_in        = l0_ff;
      neg_in       = neg_ff;
      finish_in    = finish_ff;
      few_in       = few_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      any_hit_in   = any_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_few_in   = rsp_few_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               a_in       = dq_mag;
               b_in       = dl_mag;
               d_in       = ds_mag;
               l0_in      = h_l0;
               neg_in     = dl[W];
               finish_in  = job_flags.finish;
               few_in     = job_flags.few;
               quo_in     = '0;
               any_hit_in = any_hit_ff || h_span;
               priority if (h_span && (ds_mag != '0)) begin
                  state_in = ST_MUL;
               end else if (h_span) begin
                  state_in = ST_UPD;
               end else if (job_flags.finish) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            rem_in   = prod[2*W+1:W+1];
            low_in   = prod[W:0];
            cnt_in   = CNT_W'(W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[W:0] : div_t[W:0];
            low_in = {low_ff[W-1:0], 1'b0};
            quo_in = {quo_ff[W-1:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (l_val < run_min_ff) begin
               run_min_in = l_val;
            end
            if (l_val > run_max_ff) begin
               run_max_in = l_val;
            end
            state_in = finish_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit;
               rsp_few_in   = few_ff;
               rsp_min_in   = res_hit ? run_min_ff : COORD_MAX;
               rsp_max_in   = res_hit ? run_max_ff : COORD_MIN;
               run_min_in   = COORD_MAX;
               run_max_in   = COORD_MIN;
               any_hit_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_min_ff   <= COORD_MAX;
         run_max_ff   <= COORD_MIN;
         any_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_min_ff   <= run_min_in;
         run_max_ff   <= run_max_in;
         any_hit_ff   <= any_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      d_ff       <= d_in;
      l0_ff      <= l0_in;
      neg_ff     <= neg_in;
      finish_ff  <= finish_in;
      few_ff     <= few_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_few_ff <= rsp_few_in;
      rsp_min_ff <= rsp_min_in;
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_too_few_vertices = rsp_few_ff;
   assign rsp_lateral_min      = rsp_min_ff;
   assign rsp_lateral_max      = rsp_max_ff;

endmodule

>>> rtl/psle_checker.sv
// ----------------------------------------------------------------------------
// psle_checker
// Port-level checks on the result channel of the slice extent core.
// ----------------------------------------------------------------------------
module psle_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_hit,
   input logic                   rsp_too_few_vertices,
   input logic [COORD_WIDTH-1:0] rsp_lateral_min,
   input logic [COORD_WIDTH-1:0] rsp_lateral_max
);

   localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hit_not_few: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_too_few_vertices)
      else $error("hit reported for a polygon with too few vertices");

   a_miss_sentinel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         (rsp_lateral_min == COORD_MAX) && (rsp_lateral_max == COORD_MIN))
      else $error("miss without sentinel extents");

   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> $signed(rsp_lateral_min) <= $signed(rsp_lateral_max))
      else $error("extent min above max");

endmodule

bind polygon_slice_lateral_extent_core psle_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_psle_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_hit              (rsp_hit),
   .rsp_too_few_vertices (rsp_too_few_vertices),
   .rsp_lateral_min      (rsp_lateral_min),
   .rsp_lateral_max      (rsp_lateral_max)
);

>>> tb/sv/polygon_slice_extent_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_slice_extent_checker
// Watches the vertex and result channels, tracks the polygon being sliced,
// predicts each lateral extent and compares it with what the core returns.
// ----------------------------------------------------------------------------
module polygon_slice_extent_checker #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [COORD_WIDTH-1:0] req_vertex_s,
   input  logic [COORD_WIDTH-1:0] req_vertex_l,
   input  logic [COORD_WIDTH-1:0] req_query_s,
   input  logic                   req_last_vertex,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_hit,
   input  logic                   rsp_too_few_vertices,
   input  logic [COORD_WIDTH-1:0] rsp_lateral_min,
   input  logic [COORD_WIDTH-1:0] rsp_lateral_max,
   output int                     mismatch_count,
   output int                     pending
);

   localparam int CW = COORD_WIDTH;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic          hit;
      logic          few;
      logic [CW-1:0] lat_min;
      logic [CW-1:0] lat_max;
   } extent_type;

   localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   coord_type                      first_s, first_l, prev_s, prev_l;
   coord_type                      span_min, span_max;
   logic                           spanned;
   logic [psle_pkg::VCOUNT_W-1:0]  vcount;
   extent_type                     extent_q[$];

   // Test one edge against the slicing station; fold the cut into the span.
   function automatic void slice_edge(coord_type s0, coord_type l0, coord_type s1,
                                      coord_type l1, coord_type q);
      logic signed [CW:0] ds, dl, dq;
      logic [CW:0]        ads, adl, adq;
      logic [2*CW+1:0]    prod, off;
      coord_type          cut;
      coord_type          lo_s, hi_s;
      lo_s = (s0 < s1) ? s0 : s1;
      hi_s = (s0 < s1) ? s1 : s0;
      if (q < lo_s || q > hi_s) return;
      spanned = 1'b1;
      cut = l0;
      if (s0 != s1) begin
         ds   = s1 - s0;
         dl   = l1 - l0;
         dq   = q - s0;
         ads  = (ds < 0) ? -ds : ds;
         adl  = (dl < 0) ? -dl : dl;
         adq  = (dq < 0) ? -dq : dq;
         prod = adq * adl;
         off  = prod / ads;
         // offset never exceeds |l1-l0|, so the cut stays within coord range
         cut  = (dl < 0) ? coord_type'(l0 - off[CW-1:0])
                         : coord_type'(l0 + off[CW-1:0]);
      end
      if (cut < span_min) span_min = cut;
      if (cut > span_max) span_max = cut;
   endfunction

   always @(posedge clock) begin
      extent_type got, want;
      coord_type  vs, vl, qs;
      logic       few;
      if (reset) begin
         first_s  = '0;
         first_l  = '0;
         prev_s   = '0;
         prev_l   = '0;
         span_min = COORD_MAX;
         span_max = COORD_MIN;
         spanned  = 1'b0;
         vcount   = '0;
         extent_q.delete();
         mismatch_count = 0;
      end else begin
         // results first: a result never belongs to a vertex taken at this edge
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_hit, rsp_too_few_vertices, rsp_lateral_min, rsp_lateral_max};
            if (extent_q.size() == 0) begin
               $display("%0t: unexpected result hit=%0b few=%0b min=%0d max=%0d",
                        $time, got.hit, got.few, $signed(got.lat_min),
                        $signed(got.lat_max));
               mismatch_count++;
            end else begin
               want = extent_q.pop_front();
               if (got.hit !== want.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                  mismatch_count++;
               end
               if (got.few !== want.few) begin
                  $display("%0t: too_few_vertices expected %0b actual %0b",
                           $time, want.few, got.few);
                  mismatch_count++;
               end
               if (got.lat_min !== want.lat_min) begin
                  $display("%0t: lateral_min expected %0d actual %0d", $time,
                           $signed(want.lat_min), $signed(got.lat_min));
                  mismatch_count++;
               end
               if (got.lat_max !== want.lat_max) begin
                  $display("%0t: lateral_max expected %0d actual %0d", $time,
                           $signed(want.lat_max), $signed(got.lat_max));
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            vs = req_vertex_s;
            vl = req_vertex_l;
            qs = req_query_s;
            if (vcount == 0) begin
               first_s = vs;
               first_l = vl;
            end else begin
               slice_edge(prev_s, prev_l, vs, vl, qs);
               if (req_last_vertex) slice_edge(vs, vl, first_s, first_l, qs);
            end
            prev_s = vs;
            prev_l = vl;
            if (vcount < psle_pkg::MIN_VERTICES) vcount++;
            if (req_last_vertex) begin
               few = (vcount < psle_pkg::MIN_VERTICES);
               want.hit     = !few && spanned;
               want.few     = few;
               want.lat_min = want.hit ? span_min : COORD_MAX;
               want.lat_max = want.hit ? span_max : COORD_MIN;
               extent_q.push_back(want);
               first_s  = '0;
               first_l  = '0;
               prev_s   = '0;
               prev_l   = '0;
               span_min = COORD_MAX;
               span_max = COORD_MIN;
               spanned  = 1'b0;
               vcount   = '0;
            end
         end
      end
      pending = extent_q.size();
   end

endmodule

>>> tb/sv/polygon_slice_lateral_extent_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_slice_lateral_extent_core_tb
// Feeds polygons one vertex per item into the slicing core: a directed set of
// corner cases, then random polygons with random idling on both channels.
// A checker beside the core predicts every extent; this module gives the verdict.
// ----------------------------------------------------------------------------
module polygon_slice_lateral_extent_core_tb;

   localparam int CW          = 32;
   localparam int ITEM_TARGET = 1900;
   localparam int CALM_FROM   = 1700;   // no idling past this item count
   localparam int STALL_LIMIT = 4000;   // cycles without any item moving
   localparam int TAIL_CYCLES = 100;    // wait after the last result before the verdict

   localparam logic [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] ONE_FX = CW'(1024);   // 1.0 with 10 fraction bits

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [CW-1:0] req_vertex_s = '0;
   logic [CW-1:0] req_vertex_l = '0;
   logic [CW-1:0] req_query_s = '0;
   logic          req_last_vertex = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_hit;
   logic          rsp_too_few_vertices;
   logic [CW-1:0] rsp_lateral_min;
   logic [CW-1:0] rsp_lateral_max;

   int            mismatch_count;
   int            pending;
   int            items_sent = 0;
   logic          idle_on = 1'b0;   // random idling allowed on both sides
   int            stall_left = 0;
   int            quiet_cycles = 0;

   always #4 clock = ~clock;

   polygon_slice_lateral_extent_core #(.COORD_WIDTH(CW)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_vertex_s         (req_vertex_s),
      .req_vertex_l         (req_vertex_l),
      .req_query_s          (req_query_s),
      .req_last_vertex      (req_last_vertex),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_lateral_min      (rsp_lateral_min),
      .rsp_lateral_max      (rsp_lateral_max)
   );

   polygon_slice_extent_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_vertex_s         (req_vertex_s),
      .req_vertex_l         (req_vertex_l),
      .req_query_s          (req_query_s),
      .req_last_vertex      (req_last_vertex),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_too_few_vertices (rsp_too_few_vertices),
      .rsp_lateral_min      (rsp_lateral_min),
      .rsp_lateral_max      (rsp_lateral_max),
      .mismatch_count       (mismatch_count),
      .pending              (pending)
   );

   // Result side backpressure: random bursts of stalls while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any accepted item on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance,
   // with valid still high.
   task automatic send_vertex(logic [CW-1:0] vs, logic [CW-1:0] vl,
                              logic [CW-1:0] qs, logic last);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_s    <= vs;
      req_vertex_l    <= vl;
      req_query_s     <= qs;
      req_last_vertex <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      idle_on <= (items_sent < CALM_FROM) && !(items_sent >= 800 && items_sent < 950);
   endtask

   // Hold the sender until every outstanding extent has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [CW-1:0] pick_coord(int unsigned mode);
      case (mode)
         0: return $urandom;
         1: return CW'($urandom_range(0, 16383)) - CW'(8192);
         default: begin
            case ($urandom_range(0, 4))
               0: return C_MAX;
               1: return C_MIN;
               2: return '0;
               3: return '1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // One random polygon. Query mostly falls inside the station span so the
   // interpolation path sees real work.
   task automatic random_polygon();
      logic [CW-1:0] vs[8], vl[8];
      logic [CW-1:0] qs;
      int            nv, mode;
      longint        smin, smax, sv;
      case ($urandom_range(0, 9))
         0: nv = 1;
         1: nv = 2;
         default: nv = $urandom_range(3, 7);
      endcase
      mode = $urandom_range(0, 5);
      mode = (mode < 2) ? 0 : (mode < 5) ? 1 : 2;
      smin = longint'($signed(C_MAX));
      smax = longint'($signed(C_MIN));
      for (int i = 0; i < nv; i++) begin
         vs[i] = pick_coord(mode);
         vl[i] = pick_coord(mode);
         // occasional repeated station gives a vertical edge
         if (i > 0 && $urandom_range(0, 7) == 0) vs[i] = vs[i-1];
         sv = longint'($signed(vs[i]));
         if (sv < smin) smin = sv;
         if (sv > smax) smax = sv;
      end
      for (int i = 0; i < nv; i++) begin
         if (i == 0 || $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 9))
               0, 1: qs = vs[$urandom_range(0, nv-1)];
               2, 3: qs = pick_coord($urandom_range(0, 2));
               default: qs = CW'(smin + longint'($urandom) % (smax - smin + 1));
            endcase
         end
         send_vertex(vs[i], vl[i], qs, i == nv-1);
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // triangle cut through its middle
      send_vertex('0,          '0,           2*ONE_FX, 1'b0);
      send_vertex(4*ONE_FX,    2*ONE_FX,     2*ONE_FX, 1'b0);
      send_vertex(4*ONE_FX,    -(2*ONE_FX),  2*ONE_FX, 1'b1);
      // single vertex polygon: no edge at all
      send_vertex(CW'(100),    CW'(100),     CW'(100), 1'b1);
      // two vertices: edges are hit but the polygon is too small
      send_vertex('0,          '0,           ONE_FX/2, 1'b0);
      send_vertex(ONE_FX,      ONE_FX,       ONE_FX/2, 1'b1);
      // query beyond every station: no hit
      send_vertex('0,          '0,           5*ONE_FX, 1'b0);
      send_vertex(ONE_FX,      '0,           5*ONE_FX, 1'b0);
      send_vertex('0,          ONE_FX,       5*ONE_FX, 1'b1);
      // vertical edge at the query station, query also on vertices
      send_vertex(ONE_FX,      -ONE_FX,      ONE_FX,   1'b0);
      send_vertex(ONE_FX,      ONE_FX,       ONE_FX,   1'b0);
      send_vertex(3*ONE_FX,    ONE_FX,       ONE_FX,   1'b1);
      // full range coordinates
      send_vertex(C_MIN,       C_MIN,        '0,       1'b0);
      send_vertex(C_MAX,       C_MAX,        '0,       1'b0);
      send_vertex(C_MIN,       C_MAX,        '0,       1'b1);
      send_vertex(C_MAX,       C_MIN,        C_MIN,    1'b0);
      send_vertex(C_MIN,       C_MAX,        C_MIN,    1'b0);
      send_vertex(C_MIN,       C_MIN,        C_MIN,    1'b1);
      // pentagon with the query station moving under it; count saturates
      send_vertex('0,          '0,           ONE_FX,   1'b0);
      send_vertex(2*ONE_FX,    3*ONE_FX,     ONE_FX,   1'b0);
      send_vertex(4*ONE_FX,    CW'(777),     3*ONE_FX, 1'b0);
      send_vertex(3*ONE_FX,    -(3*ONE_FX),  CW'(-5),  1'b0);
      send_vertex(ONE_FX,      -(5*ONE_FX),  2*ONE_FX, 1'b1);

      drain_results();
      idle_on <= 1'b1;

      while (items_sent < ITEM_TARGET) begin
         random_polygon();
         if ($urandom_range(0, 39) == 0) drain_results();
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
